// ===== design/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg
// Shared codes and constants of the point screen projection block.
// ----------------------------------------------------------------------------
package psp_pkg;

	// item action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_PROJECT = 1'b1;

	// coefficient store layout
	localparam int COEF_COUNT   = 28;
	localparam int VIEW_T_BASE  = 12;
	localparam int PROJ_BASE    = 16;
	localparam int PROJ_COLS    = 3;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_VIEWPORT_X      = 2'd0,
		REG_VIEWPORT_Y      = 2'd1,
		REG_VIEWPORT_WIDTH  = 2'd2,
		REG_VIEWPORT_HEIGHT = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] VIEWPORT_WIDTH_RST  = 16'd1920;
	localparam logic [15:0] VIEWPORT_HEIGHT_RST = 16'd1080;

endpackage

// ===== design/point_screen_projection.sv =====
// ----------------------------------------------------------------------------
// point_screen_projection
// Fixed-point world-to-screen perspective projection pipeline.
// ----------------------------------------------------------------------------
// The input channel (in_valid / in_stall) carries load and project items.
// A load writes one of 28 coefficients (16 view matrix entries, then
// projection columns 0, 1 and 3 by row) and gives no result. A project item
// runs through view products, view sums, projection products, clip sums,
// a restoring divider with one quotient bit per stage (two lanes, x and y),
// viewport bias, viewport scale and the output register.
// Throughput is one project item per cycle while the output is not stalled.
// The divider has DATA_WIDTH + FRAC_BITS + 1 quotient stages.
// A load is held off while a project item still sits in the first three
// stages, which read the coefficient store.
// The viewport registers are written on the cfg channel, ready always high.
// Reset clears the store, sets the viewport to 0, 0, 1920, 1080 and empties
// the pipeline. When out_stall holds a result the whole pipeline freezes and
// in_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module point_screen_projection #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic        [4:0]  coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic               behind_camera,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	localparam int DW = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * DW + 1;
	localparam int NQ = DW + F + 1;
	localparam logic signed [64:0] MAXE = (65'sd1 <<< (DW - 1)) - 65'sd1;
	localparam logic signed [64:0] MINE = -(65'sd1 <<< (DW - 1));
	localparam logic [PW-1:0] LIM = PW'(1) << (DW - 1);
	localparam logic signed [DW-1:0] ONE = DW'(65'sd1 <<< F);
	localparam logic signed [DW-1:0] THR = DW'(((64'sd1 <<< F) + 64'sd5) / 64'sd10);
	localparam logic [31:0] NEG_ONE = ~(32'd1 << F) + 32'd1;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [64:0] x);
		if (x > MAXE) return MAXE[DW-1:0];
		else if (x < MINE) return MINE[DW-1:0];
		return x[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		return sat_dw(65'(a) + 65'(b));
	endfunction

	function automatic logic signed [DW-1:0] fin(input logic neg, input logic [PW-1:0] q);
		logic [DW-1:0] t;
		t = q[DW-1:0];
		if (neg) begin
			if (q > LIM) return MINE[DW-1:0];
			return ~t + 1'b1;
		end
		if (q >= LIM) return MAXE[DW-1:0];
		return t;
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
		return a[DW-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic signed [DW-1:0] mul_q(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic [2*DW-1:0] p;
		logic [PW-1:0]   r;
		p = mag(a) * mag(b);
		r = (PW'(p) + (PW'(1) << (F - 1))) >> F;
		return fin(a[DW-1] ^ b[DW-1], r);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [DW-1:0] x);
		logic signed [64:0] e;
		e = 65'(x);
		if (e > 65'sd2147483647) return 32'h7fff_ffff;
		else if (e < -65'sd2147483648) return 32'h8000_0000;
		return e[31:0];
	endfunction

	// configuration
	logic [15:0] vp_x_q, vp_y_q, vp_w_q, vp_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_x_q <= '0;
			vp_y_q <= '0;
			vp_w_q <= psp_pkg::VIEWPORT_WIDTH_RST;
			vp_h_q <= psp_pkg::VIEWPORT_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (psp_pkg::cfg_reg_t'(cfg_index))
				psp_pkg::REG_VIEWPORT_X:      vp_x_q <= cfg_data;
				psp_pkg::REG_VIEWPORT_Y:      vp_y_q <= cfg_data;
				psp_pkg::REG_VIEWPORT_WIDTH:  vp_w_q <= cfg_data;
				psp_pkg::REG_VIEWPORT_HEIGHT: vp_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [DW-1:0] half_w, half_h, off_x, off_y;
	assign half_w = sat_dw($signed(65'(vp_w_q) << (F - 1)));
	assign half_h = sat_dw($signed(65'(vp_h_q) << (F - 1)));
	assign off_x  = sat_dw($signed(65'(vp_x_q) << F));
	assign off_y  = sat_dw($signed(65'(vp_y_q) << F));

	// handshake and pipeline advance
	logic en, accept, front_busy;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s7, v_s8, v_s9;

	assign en         = !(out_valid && out_stall);
	assign front_busy = v_s1 || v_s2 || v_s3;
	assign in_stall   = !en || (action == psp_pkg::ACT_LOAD && front_busy);
	assign accept     = in_valid && !in_stall;

	// coefficient store
	logic signed [DW-1:0] coef_q [psp_pkg::COEF_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psp_pkg::COEF_COUNT; i++) coef_q[i] <= '0;
		end else if (accept && action == psp_pkg::ACT_LOAD
				&& coef_index < 5'(psp_pkg::COEF_COUNT)) begin
			coef_q[coef_index] <= sat_dw(65'(coef_value));
		end
	end

	// stage valids
	logic dv_v_s [NQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k <= NQ; k++) dv_v_s[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && action == psp_pkg::ACT_PROJECT;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dv_v_s[0] <= v_s5;
			for (int k = 0; k < NQ; k++) dv_v_s[k+1] <= dv_v_s[k];
			v_s7 <= dv_v_s[NQ];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			out_valid <= v_s9;
		end
	end

	// stages 1 to 5: view and projection transforms
	logic signed [DW-1:0] p_s1 [3];
	logic signed [DW-1:0] vp_s2 [3][4];
	logic signed [DW-1:0] v_vec_s3 [4];
	logic signed [DW-1:0] pp_s4 [4][3];
	logic signed [DW-1:0] clip_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= sat_dw(65'(pos_x));
			p_s1[1] <= sat_dw(65'(pos_y));
			p_s1[2] <= sat_dw(65'(pos_z));
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 4; c++)
					vp_s2[r][c] <= mul_q(p_s1[r], coef_q[r*4+c]);
			for (int c = 0; c < 4; c++)
				v_vec_s3[c] <= sat_add(sat_add(sat_add(vp_s2[0][c], vp_s2[1][c]),
					vp_s2[2][c]), coef_q[psp_pkg::VIEW_T_BASE+c]);
			for (int r = 0; r < 4; r++)
				for (int k = 0; k < psp_pkg::PROJ_COLS; k++)
					pp_s4[r][k] <= mul_q(v_vec_s3[r],
						coef_q[psp_pkg::PROJ_BASE + r*psp_pkg::PROJ_COLS + k]);
			for (int k = 0; k < 3; k++)
				clip_s5[k] <= sat_add(sat_add(sat_add(pp_s4[0][k], pp_s4[1][k]),
					pp_s4[2][k]), pp_s4[3][k]);
		end
	end

	// divider: one quotient bit per stage, x and y lanes share the divisor
	logic [DW-1:0] dv_d_s [NQ+1];
	logic          dv_b_s [NQ+1];
	logic          dv_nx_s [NQ+1];
	logic          dv_ny_s [NQ+1];
	logic [DW-1:0] dv_rx_s [NQ+1];
	logic [DW-1:0] dv_ry_s [NQ+1];
	logic [NQ-1:0] dv_wx_s [NQ+1];
	logic [NQ-1:0] dv_wy_s [NQ+1];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d_s[0]  <= clip_s5[2];
			dv_b_s[0]  <= clip_s5[2] < THR;
			dv_nx_s[0] <= clip_s5[0][DW-1];
			dv_ny_s[0] <= clip_s5[1][DW-1];
			dv_rx_s[0] <= '0;
			dv_ry_s[0] <= '0;
			// dividend is |clip| scaled up plus half the divisor for rounding
			dv_wx_s[0] <= NQ'({mag(clip_s5[0]), {F{1'b0}}}) + NQ'(clip_s5[2] >>> 1);
			dv_wy_s[0] <= NQ'({mag(clip_s5[1]), {F{1'b0}}}) + NQ'(clip_s5[2] >>> 1);
		end
	end

	for (genvar k = 0; k < NQ; k++) begin : g_div
		logic [DW-1:0] sh_x, sh_y;
		logic          ge_x, ge_y;
		assign sh_x = {dv_rx_s[k][DW-2:0], dv_wx_s[k][NQ-1]};
		assign sh_y = {dv_ry_s[k][DW-2:0], dv_wy_s[k][NQ-1]};
		assign ge_x = sh_x >= dv_d_s[k];
		assign ge_y = sh_y >= dv_d_s[k];

		always_ff @(posedge clk) begin
			if (en) begin
				dv_d_s[k+1]  <= dv_d_s[k];
				dv_b_s[k+1]  <= dv_b_s[k];
				dv_nx_s[k+1] <= dv_nx_s[k];
				dv_ny_s[k+1] <= dv_ny_s[k];
				dv_rx_s[k+1] <= ge_x ? sh_x - dv_d_s[k] : sh_x;
				dv_ry_s[k+1] <= ge_y ? sh_y - dv_d_s[k] : sh_y;
				dv_wx_s[k+1] <= {dv_wx_s[k][NQ-2:0], ge_x};
				dv_wy_s[k+1] <= {dv_wy_s[k][NQ-2:0], ge_y};
			end
		end
	end

	// stages 7 to 9 and output: ndc, viewport bias and scale, offset
	logic signed [DW-1:0] ndcx_s7, ndcy_s7, bx_s8, by_s8, mx_s9, my_s9;
	logic                 b_s7, b_s8, b_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ndcx_s7 <= fin(dv_nx_s[NQ], PW'(dv_wx_s[NQ]));
			ndcy_s7 <= fin(dv_ny_s[NQ], PW'(dv_wy_s[NQ]));
			b_s7    <= dv_b_s[NQ];
			bx_s8   <= sat_add(ONE, ndcx_s7);
			by_s8   <= sat_dw(65'(ONE) - 65'(ndcy_s7));
			b_s8    <= b_s7;
			mx_s9   <= mul_q(bx_s8, half_w);
			my_s9   <= mul_q(by_s8, half_h);
			b_s9    <= b_s8;
			screen_x <= b_s9 ? NEG_ONE : sat32(sat_add(off_x, mx_s9));
			screen_y <= b_s9 ? NEG_ONE : sat32(sat_add(off_y, my_s9));
			behind_camera <= b_s9;
		end
	end

	// a project item is never held back unless the output is blocked
	a_project_flows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && en && action == psp_pkg::ACT_PROJECT |-> !in_stall)
		else $error("project item stalled with free output");

	// a load is only taken once the store readers are empty
	a_load_front_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == psp_pkg::ACT_LOAD |-> !v_s1 && !v_s2 && !v_s3)
		else $error("coefficient load while store is read");

	// a point behind the camera reports minus one on both axes
	a_behind_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && behind_camera |-> screen_x == NEG_ONE && screen_y == NEG_ONE)
		else $error("behind camera result is not minus one");

	// the pipeline freezes while the output is blocked
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(v_s9) && $stable(dv_v_s[0]))
		else $error("pipeline moved during output stall");

endmodule
